[rtl/core/mf3_pkg.sv]
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file of the filter uses it.

package mf3_pkg;

  localparam int PIX_W      = 32;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic             interior;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } tag_t;

  typedef struct packed {
    pix_t hi;
    pix_t md;
    pix_t lo;
  } col3_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col3_t r;
    pix_t  l1;
    pix_t  h1;
    pix_t  t;
    l1   = min2(a, b);
    h1   = max2(a, b);
    r.hi = max2(h1, c);
    t    = min2(h1, c);
    r.lo = min2(l1, t);
    r.md = max2(l1, t);
    return r;
  endfunction

endpackage

[rtl/core/mf3_line_buf.sv]
// Two-row line store for the 3x3 median filter, one wide word per column.
// Depends on mf3_pkg for the pixel type.

module mf3_line_buf #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [2*mf3_pkg::PIX_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [2*mf3_pkg::PIX_W-1:0] wr_data
);

  // Upper row in the high half, middle row in the low half.
  logic [2*mf3_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/mf3_median.sv]
// Median datapath: sorts each new column, keeps the window of sorted columns
// and reduces it to the median over three registered stages. Uses mf3_pkg.

module mf3_median (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  mf3_pkg::pix_t   top,
  input  mf3_pkg::pix_t   mid,
  input  mf3_pkg::pix_t   pix,
  input  mf3_pkg::tag_t   in_tag,
  output logic            out_valid,
  output mf3_pkg::pix_t   out_median,
  output mf3_pkg::tag_t   out_tag
);

  logic            v1;
  logic            v2;
  logic            v3;
  mf3_pkg::col3_t  c0;
  mf3_pkg::col3_t  c1;
  mf3_pkg::col3_t  c2;
  mf3_pkg::tag_t   tag1;
  mf3_pkg::tag_t   tag2;
  mf3_pkg::tag_t   tag3;
  mf3_pkg::pix_t   lo_max;
  mf3_pkg::pix_t   md_med;
  mf3_pkg::pix_t   hi_min;
  mf3_pkg::pix_t   median;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // The column registers move only with real pixels, so bubbles never
  // break the window.
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      c2   <= c1;
      c1   <= c0;
      c0   <= mf3_pkg::sort3(top, mid, pix);
      tag1 <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lo_max <= mf3_pkg::max3(c0.lo, c1.lo, c2.lo);
      md_med <= mf3_pkg::med3(c0.md, c1.md, c2.md);
      hi_min <= mf3_pkg::min3(c0.hi, c1.hi, c2.hi);
      tag2   <= tag1;
      median <= tag2.interior ? mf3_pkg::med3(lo_max, md_med, hi_min) : '0;
      tag3   <= tag2;
    end
  end

  assign out_valid  = v3;
  assign out_median = median;
  assign out_tag    = tag3;

endmodule

[rtl/core/median_filter_3x3.sv]
// Top level of the 3x3 median filter: stream ports, frame position counters,
// line store and median datapath. Uses mf3_pkg, mf3_line_buf and mf3_median.
//
//   Channel  Signals                           Moves
//   s_       s_tvalid s_tready s_tdata[31:0]   pixel_in
//   m_       m_tvalid m_tready m_tdata[55:0]   median_out, out_row, out_col
//            m_tuser                           out_valid
//   cfg_     cfg_valid cfg_ready cfg_index     image_width (0), image_height (1)
//            cfg_data[12:0]
//
// One pixel is accepted per cycle while the output is not stalled; every request
// gives one result, through the input/line-store read stage and three median stages.
// Reset clears the pipeline and counters; line store contents stay undefined.
// A stalled output freezes the whole pipeline, and s_tready follows it.
// A write to image_width or image_height restarts the frame at row 0, column 0.

module median_filter_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // pixel_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [55:0]                      m_tdata,   // median_out, out_row, out_col, pad
  output logic                             m_tuser,   // out_valid
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ((AW > mf3_pkg::WREG_W) ? AW : mf3_pkg::WREG_W) + 1;
  localparam int HW = mf3_pkg::HREG_W;

  logic [mf3_pkg::WREG_W-1:0] image_width;
  logic [mf3_pkg::HREG_W-1:0] image_height;
  logic [mf3_pkg::WREG_W-1:0] eff_w;
  logic [HW-1:0]              eff_h;
  logic [AW-1:0]              col_count;
  logic [mf3_pkg::ROW_W-1:0]  row_count;
  logic                       last_col;
  logic                       last_row;
  logic                       accept;
  logic                       advance;
  logic                       cfg_write;

  logic                       v0;
  mf3_pkg::pix_t              pix0;
  mf3_pkg::tag_t              tag0;
  mf3_pkg::tag_t              tag_next;
  logic [AW-1:0]              addr0;
  logic [2*mf3_pkg::PIX_W-1:0] rd_data;

  mf3_pkg::pix_t              median;
  mf3_pkg::tag_t              out_tag;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    if (image_width < mf3_pkg::WREG_W'(mf3_pkg::MIN_DIM)) begin
      eff_w = mf3_pkg::WREG_W'(mf3_pkg::MIN_DIM);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = mf3_pkg::WREG_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height < HW'(mf3_pkg::MIN_DIM)) begin
      eff_h = HW'(mf3_pkg::MIN_DIM);
    end else if (image_height > HW'(mf3_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(mf3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign last_col = (CW'(col_count) + CW'(1)) >= CW'(eff_w);
  assign last_row = (HW'(row_count) + HW'(1)) >= eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3_pkg::WREG_W'(640);
      image_height <= mf3_pkg::HREG_W'(480);
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mf3_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[mf3_pkg::WREG_W-1:0];
          col_count   <= '0;
          row_count   <= '0;
        end
        mf3_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          col_count    <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_comb begin
    tag_next.interior = (row_count >= mf3_pkg::ROW_W'(2)) && (col_count >= AW'(2));
    tag_next.row      = tag_next.interior ? row_count - 1'b1 : '0;
    tag_next.col      = tag_next.interior ? mf3_pkg::COL_W'(col_count - AW'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix0  <= s_tdata;
      tag0  <= tag_next;
      addr0 <= col_count;
    end
  end

  mf3_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (rd_data),
    .wr_en   (advance && v0),
    .wr_addr (addr0),
    .wr_data ({rd_data[mf3_pkg::PIX_W-1:0], pix0})
  );

  mf3_median u_median (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (v0),
    .top        (rd_data[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W]),
    .mid        (rd_data[mf3_pkg::PIX_W-1:0]),
    .pix        (pix0),
    .in_tag     (tag0),
    .out_valid  (m_tvalid),
    .out_median (median),
    .out_tag    (out_tag)
  );

  assign m_tdata = {1'b0, out_tag.col, out_tag.row, median};
  assign m_tuser = out_tag.interior;

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CW'(col_count) < CW'(eff_w))
    else $error("column counter outside the row");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    HW'(row_count) < eff_h)
    else $error("row counter outside the frame");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("border result carries nonzero data");

  a_interior_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_tag.row != '0 && out_tag.col != '0))
    else $error("interior result at a border position");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

endmodule

[dv/tb_top.sv]
// Self-checking bench for median_filter_3x3: drives pixel streams under several
// frame geometries and handshake idling mixes and checks each result in order.
// Depends on mf3_pkg and the filter RTL; the expected results come from a model kept here.

module tb_top;

  localparam int LINE_DEPTH   = 2048;
  localparam int PIPE_LAT     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [mf3_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [mf3_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                      valid;
    logic [mf3_pkg::COL_W-1:0] col;
    logic [mf3_pkg::ROW_W-1:0] row;
    mf3_pkg::pix_t             median;
  } window_result_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [31:0]                    s_tdata   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [55:0]                    m_tdata;
  logic                           m_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  always #2 clk = ~clk;

  median_filter_3x3 #(
    .MAX_WIDTH(LINE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [mf3_pkg::WREG_W-1:0] width_reg;
  logic [mf3_pkg::HREG_W-1:0] height_reg;
  mf3_pkg::pix_t              upper_line  [LINE_DEPTH];
  mf3_pkg::pix_t              middle_line [LINE_DEPTH];
  mf3_pkg::pix_t              win_cols    [6];
  int unsigned                col_pos;
  int unsigned                row_pos;
  window_result_t             median_q[$];

  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int unsigned pixels_taken   = 0;
  int unsigned results_seen   = 0;
  int unsigned windows_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  task automatic predict_window(input mf3_pkg::pix_t pix);
    int unsigned                    w;
    int unsigned                    h;
    int unsigned                    c;
    int unsigned                    r;
    int                             below;
    int                             same;
    mf3_pkg::pix_t                  above2;
    mf3_pkg::pix_t                  above1;
    logic [8:0][mf3_pkg::PIX_W-1:0] nb;
    window_result_t                 res;
    w = 32'(width_reg);
    if (w < mf3_pkg::MIN_DIM) w = mf3_pkg::MIN_DIM;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = 32'(height_reg);
    if (h < mf3_pkg::MIN_DIM) h = mf3_pkg::MIN_DIM;
    if (h > mf3_pkg::MAX_HEIGHT) h = mf3_pkg::MAX_HEIGHT;
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    above2 = upper_line[c];
    above1 = middle_line[c];
    res = '0;
    if (r >= 2 && c >= 2) begin
      nb[0] = win_cols[0];
      nb[1] = win_cols[3];
      nb[2] = above2;
      nb[3] = win_cols[1];
      nb[4] = win_cols[4];
      nb[5] = above1;
      nb[6] = win_cols[2];
      nb[7] = win_cols[5];
      nb[8] = pix;
      // The median is the word with at most four smaller words and at least five
      // words that are smaller or equal.
      for (int i = 0; i < 9; i++) begin
        below = 0;
        same  = 0;
        for (int j = 0; j < 9; j++) begin
          if (nb[j] < nb[i]) below++;
          else if (nb[j] == nb[i]) same++;
        end
        if (below <= 4 && below + same > 4) res.median = nb[i];
      end
      res.valid = 1'b1;
      res.row   = mf3_pkg::ROW_W'(r - 1);
      res.col   = mf3_pkg::COL_W'(c - 1);
    end
    upper_line[c]  = above1;
    middle_line[c] = pix;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = above2;
    win_cols[4] = above1;
    win_cols[5] = pix;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
    median_q.push_back(res);
  endtask

  function automatic void check_field(input string field, input mf3_pkg::pix_t want,
                                      input mf3_pkg::pix_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      width_reg  = 12'd640;
      height_reg = 13'd480;
      col_pos    = 0;
      row_pos    = 0;
      foreach (win_cols[i]) win_cols[i] = '0;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      median_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mf3_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[mf3_pkg::WREG_W-1:0];
            col_pos   = 0;
            row_pos   = 0;
          end
          mf3_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[mf3_pkg::HREG_W-1:0];
            col_pos    = 0;
            row_pos    = 0;
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_window(s_tdata);
        pixels_taken++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (median_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
                   $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = median_q.pop_front();
          if (want.valid) windows_seen++;
          check_field("out_valid", mf3_pkg::pix_t'(want.valid), mf3_pkg::pix_t'(m_tuser));
          check_field("median_out", want.median, m_tdata[31:0]);
          check_field("out_row", mf3_pkg::pix_t'(want.row), mf3_pkg::pix_t'(m_tdata[43:32]));
          check_field("out_col", mf3_pkg::pix_t'(want.col), mf3_pkg::pix_t'(m_tdata[54:44]));
          check_field("tdata pad", '0, mf3_pkg::pix_t'(m_tdata[55]));
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic mf3_pkg::pix_t rand_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return mf3_pkg::pix_t'($urandom_range(3));
      3: return 32'h8000_0000 | $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic send_pixel(input mf3_pkg::pix_t pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (s_tready !== 1'b1);
  endtask

  task automatic stream_pixels(input int unsigned count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (median_q.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mf3_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_geometry();
    // Reset leaves a 640-pixel row, so the first pixels all lie on the top border.
    set_idling(0, 0);
    stream_pixels(40);
    wait_idle();
  endtask

  task automatic test_pixel_extremes();
    mf3_pkg::pix_t corner_pix [18];
    corner_pix = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFE,
                   32'h0000_0000,
                   32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h0000_0000,
                   32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                   32'h5A5A_5A5A};
    write_reg(mf3_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 13'd3);
    foreach (corner_pix[i]) send_pixel(corner_pix[i]);
    wait_idle();
  endtask

  task automatic test_register_writes();
    // Bit 12 of a width write is dropped and small values saturate. Writes to
    // the spare indexes must leave the frame position alone.
    write_reg(mf3_pkg::REG_IMAGE_WIDTH, 13'h1004);
    write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 13'd2);
    stream_pixels(5);
    write_reg(REG_SPARE_2, 13'h1FFF);
    write_reg(REG_SPARE_3, 13'h0AAA);
    stream_pixels(7);
    write_reg(mf3_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 13'd0);
    stream_pixels(9);
    wait_idle();
  endtask

  task automatic test_widest_rows();
    // A width past the line store saturates to its depth; the pixels stay in row 0.
    write_reg(mf3_pkg::REG_IMAGE_WIDTH, 13'd4095);
    write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 13'd3);
    stream_pixels(40);
    wait_idle();
  endtask

  task automatic test_tallest_frame();
    // An oversized height saturates while narrow rows still give windows.
    write_reg(mf3_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    stream_pixels(30);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned src_mix [4];
    int unsigned snk_mix [4];
    int unsigned chunk;
    src_mix = '{0, 87, 0, 31};
    snk_mix = '{0, 0, 87, 31};
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(src_mix[ph], snk_mix[ph]);
      repeat (2) begin
        write_reg(mf3_pkg::REG_IMAGE_WIDTH, mf3_pkg::CFG_DATA_W'($urandom_range(14)));
        write_reg(mf3_pkg::REG_IMAGE_HEIGHT, mf3_pkg::CFG_DATA_W'($urandom_range(9)));
        chunk = $urandom_range(35, 55);
        stream_pixels(chunk / 2);
        wait_idle();
        stream_pixels(chunk - chunk / 2);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_geometry();
    test_pixel_extremes();
    test_register_writes();
    test_widest_rows();
    test_tallest_frame();
    test_random_traffic();
    wait_idle();
    repeat (4 * PIPE_LAT) @(posedge clk);
    $display("Streamed %0d pixel requests and checked %0d results, %0d of them full windows,",
             pixels_taken, results_seen, windows_seen);
    $display("over default, saturated and small wrapping frames under four idling mixes.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mf3_pkg.sv
rtl/core/mf3_line_buf.sv
rtl/core/mf3_median.sv
rtl/core/median_filter_3x3.sv
dv/tb_top.sv
